@@ hdl/fsfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte function for the frame decoder.
package fsfd_pkg;

  // Frame layout and checksum
  localparam int          WORDS_PER_FRAME_DEF = 3;
  localparam logic [7:0]  CRC_INIT = 8'hFF;
  localparam logic [7:0]  CRC_POLY = 8'h31;

  // Result status codes
  localparam logic [1:0]  STATUS_OK      = 2'd0;
  localparam logic [1:0]  STATUS_BUS_ERR = 2'd1;
  localparam logic [1:0]  STATUS_CRC_ERR = 2'd2;

  // Configuration port
  localparam int          CFG_DATA_W = 16;
  localparam int          CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_FLAG_MASK = 2'd2;

  localparam logic [15:0] FLOW_SCALE_RST    = 16'd2000;
  localparam logic [7:0]  TEMP_SCALE_RST    = 8'd5;
  localparam logic [15:0] AIR_FLAG_MASK_RST = 16'd1;

  // One input item
  typedef struct packed {
    logic [7:0] byte_value;
    logic       bus_error;
  } byte_item_t;

  // One result item
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] flow_nl_per_min;
    logic signed [23:0] temp_millic;
    logic [15:0]        flag_word;
    logic               air_detected;
  } result_item_t;

  // Decoded frame waiting for scaling; words are zero on error
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] flow_word;
    logic [15:0] temp_word;
    logic [15:0] flag_word;
  } frame_words_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] flow_scale;
    logic [7:0]  temp_scale;
    logic [15:0] air_flag_mask;
  } cfg_regs_t;

  // CRC-8, MSB first, one byte folded in
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ hdl/fsfd_frame_parser.sv @@
// Frame parser: byte position tracking, CRC checking and word capture.
module fsfd_frame_parser
  import fsfd_pkg::*;
#(
  parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_item_t   byte_item,
  input  logic         advance,
  output logic         pend_valid,
  output frame_words_t pend
);

  localparam int WIDX_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS_PER_FRAME - 1);

  localparam logic [1:0] PH_HIGH = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_CRC  = 2'd2;

  logic [1:0]        phase;
  logic [WIDX_W-1:0] word_idx;
  logic [7:0]        running_crc;
  logic [7:0]        high_byte;
  logic [15:0]       flow_word;
  logic [15:0]       temp_word;
  logic [15:0]       flag_reg;
  logic              crc_failed;

  logic         accept;
  logic [7:0]   crc_step;
  logic [15:0]  word_in;
  logic         frame_end;
  logic         crc_fail_now;
  frame_words_t pend_next;

  // Hold off new bytes only while a finished frame cannot move on
  assign byte_stall = pend_valid && !advance;
  assign accept     = byte_valid && !byte_stall;

  assign crc_step     = crc8_byte((phase == PH_HIGH) ? CRC_INIT : running_crc,
                                  byte_item.byte_value);
  assign word_in      = {high_byte, byte_item.byte_value};
  assign frame_end    = (phase == PH_CRC) && (word_idx == LAST_WORD);
  assign crc_fail_now = crc_failed || (running_crc != byte_item.byte_value);

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HIGH;
      word_idx    <= '0;
      running_crc <= CRC_INIT;
      crc_failed  <= 1'b0;
      high_byte   <= '0;
      flow_word   <= '0;
      temp_word   <= '0;
      flag_reg    <= '0;
    end else if (accept) begin
      if (byte_item.bus_error) begin
        phase       <= PH_HIGH;
        word_idx    <= '0;
        running_crc <= CRC_INIT;
        crc_failed  <= 1'b0;
      end else begin
        case (phase)
          PH_HIGH: begin
            running_crc <= crc_step;
            high_byte   <= byte_item.byte_value;
            phase       <= PH_LOW;
          end
          PH_LOW: begin
            running_crc <= crc_step;
            if (word_idx == '0) flow_word <= word_in;
            if ((WORDS_PER_FRAME > 1) && (word_idx == WIDX_W'(1))) temp_word <= word_in;
            if ((WORDS_PER_FRAME > 2) && (word_idx == WIDX_W'(2))) flag_reg <= word_in;
            phase <= PH_CRC;
          end
          default: begin
            phase <= PH_HIGH;
            if (frame_end) begin
              word_idx    <= '0;
              running_crc <= CRC_INIT;
              crc_failed  <= 1'b0;
            end else begin
              word_idx   <= word_idx + 1'b1;
              crc_failed <= crc_fail_now;
            end
          end
        endcase
      end
    end
  end

  // Finished-frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (advance || !pend_valid) begin
      pend_valid <= accept && (byte_item.bus_error || frame_end);
    end
  end

  // Finished-frame contents: words only when every word checked out
  always_comb begin
    pend_next = '0;
    if (byte_item.bus_error) begin
      pend_next.status = STATUS_BUS_ERR;
    end else if (crc_fail_now) begin
      pend_next.status = STATUS_CRC_ERR;
    end else begin
      pend_next.status    = STATUS_OK;
      pend_next.flow_word = flow_word;
      pend_next.temp_word = (WORDS_PER_FRAME > 1) ? temp_word : 16'd0;
      pend_next.flag_word = (WORDS_PER_FRAME > 2) ? flag_reg : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance || !pend_valid) begin
      pend <= pend_next;
    end
  end

endmodule

@@ hdl/fsfd_scaler.sv @@
// Scaler: applies flow and temperature scales and the air mask into the result register.
module fsfd_scaler
  import fsfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         pend_valid,
  input  frame_words_t pend,
  input  cfg_regs_t    cfg,
  output logic         result_valid,
  output result_item_t result_item
);

  logic signed [32:0] flow_prod;
  logic signed [24:0] temp_prod;

  // Signed word times unsigned scale
  assign flow_prod = $signed(pend.flow_word) * $signed({1'b0, cfg.flow_scale});
  assign temp_prod = $signed(pend.temp_word) * $signed({1'b0, cfg.temp_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item.status          <= pend.status;
      result_item.flow_nl_per_min <= flow_prod[31:0];
      result_item.temp_millic     <= temp_prod[23:0];
      result_item.flag_word       <= pend.flag_word;
      result_item.air_detected    <= |(pend.flag_word & cfg.air_flag_mask);
    end
  end

endmodule

@@ hdl/flow_sensor_frame_decoder.sv @@
// Top level of the sensor frame decoder: configuration registers and pipeline wiring.
// Path: once the last byte of a frame (or a bus-error byte) is accepted, the finished
// frame is registered in the frame register and then in the scaler's result register.
// Throughput: one byte per cycle unless byte_stall holds it off; the frame register and
// result register stall together only when a result is held back at the output.
// Reset (synchronous, active high) restarts the frame, empties both stages and
// restores the scale and mask registers to their defaults.
module flow_sensor_frame_decoder
  import fsfd_pkg::*;
#(
  parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  byte_item_t            byte_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_item_t          result_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t    cfg;
  logic         advance;
  logic         pend_valid;
  frame_words_t pend;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_scale    <= FLOW_SCALE_RST;
      cfg.temp_scale    <= TEMP_SCALE_RST;
      cfg.air_flag_mask <= AIR_FLAG_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLOW_SCALE:    cfg.flow_scale    <= cfg_data;
        REG_TEMP_SCALE:    cfg.temp_scale    <= cfg_data[7:0];
        REG_AIR_FLAG_MASK: cfg.air_flag_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the result register is free or being taken
  assign advance = !result_valid || !result_stall;

  fsfd_frame_parser #(
    .WORDS_PER_FRAME(WORDS_PER_FRAME)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .advance    (advance),
    .pend_valid (pend_valid),
    .pend       (pend)
  );

  fsfd_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .pend_valid   (pend_valid),
    .pend         (pend),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

endmodule

@@ test/tb.sv @@
// Testbench for the sensor frame decoder: framed byte stream in, results checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsfd_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int FRAME_LEN       = 3 * WORDS_PER_FRAME_DEF;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 271;
  localparam int LONG_HOLD       = 150;
  localparam int CYCLE_LIMIT     = 200000;
  // Index with no register behind it; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {FRAME_CLEAN, FRAME_BAD_CRC, FRAME_ABORTED} frame_kind_t;

  // Predicts decoded readings from accepted bytes and checks the results
  class reading_checker;
    result_item_t pending[$];
    int           errors;
    logic [15:0]  flow_scale;
    logic [7:0]   temp_scale;
    logic [15:0]  air_mask;
    int           pos;
    logic [7:0]   crc;
    logic [7:0]   hi;
    logic [15:0]  flow_w;
    logic [15:0]  temp_w;
    logic [15:0]  flag_w;
    bit           crc_bad;

    function new();
      errors     = 0;
      flow_scale = FLOW_SCALE_RST;
      temp_scale = TEMP_SCALE_RST;
      air_mask   = AIR_FLAG_MASK_RST;
      hi         = '0;
      flow_w     = '0;
      temp_w     = '0;
      flag_w     = '0;
      restart_frame();
    endfunction

    function void restart_frame();
      pos     = 0;
      crc     = CRC_INIT;
      crc_bad = 1'b0;
    endfunction

    // Bit-serial LFSR form, MSB of the data first
    function logic [7:0] crc_fold(logic [7:0] acc, logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FLOW_SCALE:    flow_scale = val;
        REG_TEMP_SCALE:    temp_scale = val[7:0];
        REG_AIR_FLAG_MASK: air_mask = val;
        default: ;
      endcase
    endfunction

    function void take_byte(byte_item_t it);
      result_item_t r;
      logic [15:0]  w;
      longint       f;
      longint       t;
      r = '0;
      // Bus error drops the byte and reports at once
      if (it.bus_error) begin
        r.status = STATUS_BUS_ERR;
        pending.push_back(r);
        restart_frame();
        return;
      end
      case (pos % 3)
        0: begin
          crc = crc_fold(CRC_INIT, it.byte_value);
          hi  = it.byte_value;
        end
        1: begin
          crc = crc_fold(crc, it.byte_value);
          w   = {hi, it.byte_value};
          case (pos / 3)
            0: flow_w = w;
            1: temp_w = w;
            2: flag_w = w;
            default: ;
          endcase
        end
        default: if (crc != it.byte_value) crc_bad = 1'b1;
      endcase
      pos++;
      if (pos < FRAME_LEN) return;
      // End of frame: measurement fields only when every word checked out
      if (crc_bad) begin
        r.status = STATUS_CRC_ERR;
      end else begin
        f = longint'($signed(flow_w)) * longint'(flow_scale);
        t = longint'($signed(temp_w)) * longint'(temp_scale);
        r.status          = STATUS_OK;
        r.flow_nl_per_min = f[31:0];
        r.temp_millic     = t[23:0];
        r.flag_word       = flag_w;
        r.air_detected    = |(flag_w & air_mask);
      end
      pending.push_back(r);
      restart_frame();
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
      if (got !== exp) begin
        $display("%0t: %s expected %h got %h", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_reading(result_item_t got);
      result_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      compare_field("status", exp.status, got.status);
      compare_field("flow_nl_per_min", exp.flow_nl_per_min, got.flow_nl_per_min);
      compare_field("temp_millic", exp.temp_millic, got.temp_millic);
      compare_field("flag_word", exp.flag_word, got.flag_word);
      compare_field("air_detected", exp.air_detected, got.air_detected);
    endfunction

    function void check_drained();
      if (pending.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, pending.size());
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  byte_item_t            byte_item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_item_t          result_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reading_checker readings;
  int send_idle_pct = 30;
  int recv_idle_pct = 55;
  int items_sent = 0;
  int hold_left = 0;
  int cycle_count = 0;
  logic long_hold_due = 1'b0;

  flow_sensor_frame_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stall, or a long hold-off when asked for
  always @(posedge clk) begin
    if (long_hold_due && hold_left == 0) begin
      long_hold_due <= 1'b0;
      hold_left     <= LONG_HOLD;
      result_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) readings.take_byte(byte_item);
      if (result_valid && !result_stall) readings.check_reading(result_item);
    end
  end

  // Offer one item, with random idle cycles ahead of it
  task automatic offer_byte(input byte_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    readings.set_reg(idx, val);
  endtask

  // Stop offering, wait for every result and let the pipeline empty
  task automatic settle();
    byte_valid <= 1'b0;
    cfg_we     <= 1'b0;
    @(posedge clk);
    while (readings.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One frame of three checked words; optionally a bad CRC or a bus abort after cut bytes
  task automatic send_frame(input logic [15:0] flow, input logic [15:0] temp,
                            input logic [15:0] flags, input frame_kind_t kind, input int cut);
    logic [7:0]  frame_bytes [FRAME_LEN];
    logic [15:0] words [3];
    byte_item_t  it;
    int          bad;
    words[0] = flow;
    words[1] = temp;
    words[2] = flags;
    for (int k = 0; k < 3; k++) begin
      frame_bytes[3*k]   = words[k][15:8];
      frame_bytes[3*k+1] = words[k][7:0];
      frame_bytes[3*k+2] = readings.crc_fold(readings.crc_fold(CRC_INIT, words[k][15:8]),
                                             words[k][7:0]);
    end
    if (kind == FRAME_BAD_CRC) begin
      bad = 3 * $urandom_range(2) + 2;
      frame_bytes[bad] ^= 8'h01 << $urandom_range(7);
    end
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (kind == FRAME_ABORTED && i == cut) begin
        it.byte_value = 8'($urandom);
        it.bus_error  = 1'b1;
        offer_byte(it);
        return;
      end
      it.byte_value = frame_bytes[i];
      it.bus_error  = 1'b0;
      offer_byte(it);
    end
  endtask

  // Random bytes, then a bus error to bring framing back in step
  task automatic send_noise();
    byte_item_t it;
    int         n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      it.byte_value = 8'($urandom);
      it.bus_error  = ($urandom_range(15) == 0);
      offer_byte(it);
    end
    it.byte_value = 8'($urandom);
    it.bus_error  = 1'b1;
    offer_byte(it);
  endtask

  task automatic run_random(input int quota);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 70) send_frame(pick_word(), pick_word(), pick_word(), FRAME_CLEAN, 0);
      else if (pick < 80) send_frame(pick_word(), pick_word(), pick_word(), FRAME_BAD_CRC, 0);
      else if (pick < 90) send_frame(pick_word(), pick_word(), pick_word(), FRAME_ABORTED,
                                     $urandom_range(FRAME_LEN - 1));
      else send_noise();
    end
  endtask

  initial begin
    logic [7:0] junk;
    readings = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: word extremes, CRC failure, bus error at frame start and mid-frame
    send_frame(16'h7FFF, 16'h8000, 16'hFFFF, FRAME_CLEAN, 0);
    send_frame(16'h8000, 16'h7FFF, 16'h0000, FRAME_BAD_CRC, 0);
    send_frame(16'h1234, 16'h5678, 16'h9ABC, FRAME_ABORTED, 0);
    send_frame(16'hFFFF, 16'h0001, 16'h0002, FRAME_ABORTED, 4);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      junk = 8'($urandom);
      case (p)
        0: begin
          write_reg(REG_FLOW_SCALE, 16'd1);
          write_reg(REG_TEMP_SCALE, {junk, 8'd1});
          write_reg(REG_AIR_FLAG_MASK, 16'h0000);
        end
        1: begin
          write_reg(REG_FLOW_SCALE, 16'hFFFF);
          write_reg(REG_TEMP_SCALE, {junk, 8'd255});
          write_reg(REG_AIR_FLAG_MASK, 16'hFFFF);
        end
        2: begin
          // zero scales give zero readings
          write_reg(REG_FLOW_SCALE, 16'd0);
          write_reg(REG_TEMP_SCALE, 16'd0);
          write_reg(REG_AIR_FLAG_MASK, 16'($urandom));
          write_reg(REG_UNUSED, 16'($urandom));
        end
        3: begin
          write_reg(REG_FLOW_SCALE, 16'($urandom_range(1, 65535)));
          write_reg(REG_TEMP_SCALE, {junk, 8'($urandom_range(1, 255))});
          write_reg(REG_AIR_FLAG_MASK, 16'($urandom));
        end
        4: begin
          write_reg(REG_FLOW_SCALE, 16'($urandom_range(1, 65535)));
          write_reg(REG_TEMP_SCALE, 16'($urandom_range(1, 255)));
          write_reg(REG_AIR_FLAG_MASK, 16'h0001 << $urandom_range(15));
        end
        default: begin
          write_reg(REG_FLOW_SCALE, FLOW_SCALE_RST);
          write_reg(REG_TEMP_SCALE, 16'(TEMP_SCALE_RST));
          write_reg(REG_AIR_FLAG_MASK, AIR_FLAG_MASK_RST);
        end
      endcase
      cfg_we <= 1'b0;

      // Idling pattern: sender light, then receiver light, then none
      case (p / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct <= 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct <= 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      // Long receiver hold-off so the block backs up and stalls its input
      if (p == 1 || p == 4) long_hold_due <= 1'b1;

      run_random(ITEMS_PER_PHASE);
      settle();
    end

    readings.check_drained();
    if (readings.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
